FILE: src/tcce_pkg.sv
// Shared widths, codes and types of the text console cursor engine.
`default_nettype none

package tcce_pkg;

   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = 16;
   localparam int INDEX_W     = 11;
   localparam int OPC_W       = 2;
   localparam int KIND_W      = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;

   // command queue depth, a power of two so that the pointers wrap by themselves
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OPC_W-1:0] OP_PUT_BYTE = 2'd0;
   localparam logic [OPC_W-1:0] OP_MOVE     = 2'd1;
   localparam logic [OPC_W-1:0] OP_RESTORE  = 2'd2;
   localparam logic [OPC_W-1:0] OP_READ     = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ATTRIBUTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ROW      = 1'b1;

   localparam logic [CHAR_W-1:0] BYTE_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] BYTE_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] BYTE_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] BYTE_CR  = 8'h0D;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   localparam logic [KIND_W-1:0] KIND_NOP     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CR      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LF      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BS      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PRINT   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MOVE    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd6;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  char_code;
      logic [COL_W-1:0]   target_col;
      logic [ROW_W-1:0]   target_row;
      logic [INDEX_W-1:0] cell_index;
      logic               in_range;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

FILE: src/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/tcce_front.sv
// Front end: accepts request words, classifies them and queues commands.
`default_nettype none

module tcce_front #(
   parameter int NUM_COLUMNS = 80,
   parameter int NUM_ROWS    = 25
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [tcce_pkg::OPC_W-1:0]        req_opcode,
   input  wire logic [tcce_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [tcce_pkg::COL_W-1:0]        req_target_col,
   input  wire logic [tcce_pkg::ROW_W-1:0]        req_target_row,
   input  wire logic [tcce_pkg::INDEX_W-1:0]      req_cell_index,
   output logic                                   cmd_valid,
   output tcce_pkg::cmd_type                      cmd,
   input  tcce_pkg::back_status_type              status
);

   import tcce_pkg::*;

   localparam int GridCells = NUM_COLUMNS * NUM_ROWS;
   localparam int PtrW      = $clog2(QUEUE_DEPTH);
   localparam int CntW      = $clog2(QUEUE_DEPTH + 1);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   cmd_type           cls;
   logic              push;
   logic              full;

   // decode the request into a command for the back end
   always_comb begin
      cls            = '0;
      cls.kind       = KIND_NOP;
      cls.char_code  = req_char_code;
      cls.target_col = req_target_col;
      cls.target_row = req_target_row;
      cls.cell_index = req_cell_index;
      unique case (req_opcode)
         OP_PUT_BYTE: begin
            unique case (req_char_code)
               BYTE_LF:  cls.kind = KIND_LF;
               BYTE_CR:  cls.kind = KIND_CR;
               BYTE_BS:  cls.kind = KIND_BS;
               BYTE_NUL: cls.kind = KIND_NOP;
               default:  cls.kind = KIND_PRINT;
            endcase
         end
         OP_MOVE: begin
            cls.kind     = KIND_MOVE;
            cls.in_range = (32'(req_target_col) < NUM_COLUMNS) &&
                           (32'(req_target_row) < NUM_ROWS);
         end
         OP_RESTORE: begin
            cls.kind = KIND_RESTORE;
         end
         OP_READ: begin
            cls.kind     = KIND_READ;
            cls.in_range = 32'(req_cell_index) < GridCells;
         end
      endcase
   end

   assign full      = count_ff == CntW'(QUEUE_DEPTH);
   assign req_stall = status.clearing || full;
   assign push      = req_valid && !req_stall;
   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PtrW'(1);
      end
      if (status.pop) begin
         rd_ptr_in = rd_ptr_ff + PtrW'(1);
      end
      if (push && !status.pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!push && status.pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> !(count_ff > CntW'(QUEUE_DEPTH)))
      else $error("command queue overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> cmd_valid)
      else $error("pop from empty command queue");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !push)
      else $error("word taken during clearing pass");

endmodule

`default_nettype wire

FILE: src/tcce_back.sv
// Back end: cursor state, screen store, scrolling and the result register.
`default_nettype none

module tcce_back #(
   parameter int NUM_COLUMNS = 80,
   parameter int NUM_ROWS    = 25
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tcce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcce_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              cmd_valid,
   input  tcce_pkg::cmd_type                      cmd,
   output tcce_pkg::back_status_type              status,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tcce_pkg::COL_W-1:0]             rsp_cursor_col,
   output logic [tcce_pkg::ROW_W-1:0]             rsp_cursor_row,
   output logic [tcce_pkg::CELL_W-1:0]            rsp_cell_data
);

   import tcce_pkg::*;

   localparam int GridCells = NUM_COLUMNS * NUM_ROWS;
   localparam int AddrW     = $clog2(GridCells);

   localparam logic [AddrW-1:0] LastCell    = AddrW'(GridCells - 1);
   localparam logic [AddrW-1:0] LastRowBase = AddrW'(GridCells - NUM_COLUMNS);
   localparam logic [AddrW-1:0] RowStride   = AddrW'(NUM_COLUMNS);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   saved_col_ff, saved_col_in;
   logic [ROW_W-1:0]   saved_row_ff, saved_row_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [AddrW-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [AddrW-1:0]   pend_addr_ff, pend_addr_in;
   cmd_type            cmd_ff, cmd_in;
   logic [AddrW-1:0]   row_base_ff, row_base_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [AddrW-1:0]   ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic [AddrW-1:0]   ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;

   logic               pop;
   logic               finish;
   logic               line_feed;
   logic [CELL_W-1:0]  fin_data;
   logic [COL_W:0]     col_inc;
   logic [ROW_W:0]     row_inc;

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (GridCells)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign col_inc = {1'b0, cur_col_ff} + (COL_W+1)'(1);
   assign row_inc = {1'b0, cur_row_ff} + (ROW_W+1)'(1);

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      saved_col_in = saved_col_ff;
      saved_row_in = saved_row_ff;
      attr_in      = attr_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      cmd_in       = cmd_ff;
      row_base_in  = row_base_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = BLANK_CELL;
      ram_raddr    = cnt_ff + RowStride;
      pop          = 1'b0;
      finish       = 1'b0;
      line_feed    = 1'b0;
      fin_data     = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (cnt_ff == LastCell) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AddrW'(1);
            end
         end
         S_IDLE: begin
            // take the next command only once the result slot is free
            if (cmd_valid && !rsp_valid_ff) begin
               pop         = 1'b1;
               cmd_in      = cmd;
               row_base_in = AddrW'(AddrW'(cur_row_ff) * RowStride);
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff.kind)
               KIND_NOP: begin
                  finish = 1'b1;
               end
               KIND_CR: begin
                  cur_col_in = '0;
                  finish     = 1'b1;
               end
               KIND_LF: begin
                  cur_col_in = '0;
                  line_feed  = 1'b1;
               end
               KIND_BS: begin
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - COL_W'(1);
                     ram_we     = 1'b1;
                     ram_waddr  = row_base_ff + AddrW'(cur_col_ff - COL_W'(1));
                  end
                  finish = 1'b1;
               end
               KIND_PRINT: begin
                  ram_we    = 1'b1;
                  ram_waddr = row_base_ff + AddrW'(cur_col_ff);
                  ram_wdata = {attr_ff, cmd_ff.char_code};
                  if (col_inc == (COL_W+1)'(NUM_COLUMNS)) begin
                     cur_col_in = '0;
                     line_feed  = 1'b1;
                  end else begin
                     cur_col_in = col_inc[COL_W-1:0];
                     finish     = 1'b1;
                  end
               end
               KIND_MOVE: begin
                  saved_col_in = cur_col_ff;
                  saved_row_in = cur_row_ff;
                  if (cmd_ff.in_range) begin
                     cur_col_in = cmd_ff.target_col;
                     cur_row_in = cmd_ff.target_row;
                  end
                  finish = 1'b1;
               end
               KIND_RESTORE: begin
                  cur_col_in = saved_col_ff;
                  cur_row_in = saved_row_ff;
                  finish     = 1'b1;
               end
               KIND_READ: begin
                  if (cmd_ff.in_range) begin
                     ram_raddr = AddrW'(cmd_ff.cell_index);
                     state_in  = S_READ;
                  end else begin
                     fin_data = BLANK_CELL;
                     finish   = 1'b1;
                  end
               end
            endcase
            if (line_feed) begin
               if (row_inc < (ROW_W+1)'(NUM_ROWS)) begin
                  cur_row_in = row_inc[ROW_W-1:0];
                  finish     = 1'b1;
               end else begin
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCROLL;
               end
            end
         end
         S_READ: begin
            fin_data = ram_rdata;
            finish   = 1'b1;
         end
         S_SCROLL: begin
            // copy cell i+stride down to i; the write lands in the cycle after its read
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = ram_rdata;
               pend_in   = 1'b0;
            end
            if (cnt_ff < LastRowBase) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in       = cnt_ff + AddrW'(1);
            end else if (!pend_ff) begin
               // blank the bottom row
               ram_we = 1'b1;
               if (cnt_ff == LastCell) begin
                  cnt_in = '0;
                  finish = 1'b1;
               end else begin
                  cnt_in = cnt_ff + AddrW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_col_in   = cur_col_in;
         rsp_row_in   = cur_row_in;
         rsp_data_in  = fin_data;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_TEXT_ATTRIBUTE: begin
               attr_in = csr_wdata;
            end
            CSR_START_ROW: begin
               if (32'(csr_wdata[ROW_W-1:0]) < NUM_ROWS) begin
                  cur_col_in = '0;
                  cur_row_in = csr_wdata[ROW_W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         saved_col_ff <= '0;
         saved_row_ff <= '0;
         attr_ff      <= ATTR_RESET;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         saved_col_ff <= saved_col_in;
         saved_row_ff <= saved_row_in;
         attr_ff      <= attr_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      cmd_ff       <= cmd_in;
      row_base_ff  <= row_base_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign status.pop      = pop;
   assign status.clearing = state_ff == S_CLEAR;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_data  = rsp_data_ff;

   a_cursor_on_grid: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_col_ff) < NUM_COLUMNS) && (32'(cur_row_ff) < NUM_ROWS))
      else $error("cursor left the grid");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid_ff && cmd_valid))
      else $error("command taken while result slot busy");

   a_pend_in_scroll: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCROLL))
      else $error("pending copy outside scroll");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("store written while idle");

   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished command gave no result");

endmodule

`default_nettype wire

FILE: src/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: front end, command queue and back end.
`default_nettype none

// Text console engine over a NUM_COLUMNS by NUM_ROWS grid of 16-bit cells
// (attribute high byte, character low byte). Each request word yields one
// response word with the cursor after the operation; a cell read also returns
// the cell, other operations return zero. Words pass through a two-entry
// command queue, so the front keeps taking words while a response waits. The
// back end takes a command from the queue, executes it and registers the
// response; a read of a cell on the grid passes through a further read state.
// A line feed on the bottom row scrolls the whole store through its single
// read and write port. After reset a clearing pass writes every cell blank,
// one cell a cycle, with req_stall held high; register writes are taken
// throughout. Reads beyond the grid return the blank cell.
module text_console_cursor_engine_unit #(
   parameter int NUM_COLUMNS = 80,
   parameter int NUM_ROWS    = 25
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tcce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcce_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [tcce_pkg::OPC_W-1:0]        req_opcode,
   input  wire logic [tcce_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [tcce_pkg::COL_W-1:0]        req_target_col,
   input  wire logic [tcce_pkg::ROW_W-1:0]        req_target_row,
   input  wire logic [tcce_pkg::INDEX_W-1:0]      req_cell_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tcce_pkg::COL_W-1:0]             rsp_cursor_col,
   output logic [tcce_pkg::ROW_W-1:0]             rsp_cursor_row,
   output logic [tcce_pkg::CELL_W-1:0]            rsp_cell_data
);

   import tcce_pkg::*;

   logic            cmd_valid;
   cmd_type         cmd;
   back_status_type status;

   tcce_front #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_ROWS    (NUM_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .req_cell_index (req_cell_index),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .status         (status)
   );

   tcce_back #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_ROWS    (NUM_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_data  (rsp_cell_data)
   );

endmodule

`default_nettype wire
